// ----- design/vacn_pkg.sv -----
// ----------------------------------------------------------------------------
// vacn_pkg
// Shared types, constants and helpers for the vector accumulate / cross /
// normalize block.
// ----------------------------------------------------------------------------
package vacn_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int W          = 32;
	localparam int PROD_W     = 2 * W;
	localparam int DIFF_W     = PROD_W + 1;
	localparam int REM_W      = W + 4;
	localparam int SQRT_STEPS = W;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int MUL_CROSS  = 6;
	localparam int MUL_NORM   = 3;
	localparam int CNT_MAX    = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
	localparam int CNT_W      = $clog2(CNT_MAX);

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_CROSS = 2'd2,
		KIND_NORM  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic signed [W-1:0] op_x;
		logic signed [W-1:0] op_y;
		logic signed [W-1:0] op_z;
	} in_item_t;

	typedef struct packed {
		logic signed [W-1:0] res_x;
		logic signed [W-1:0] res_y;
		logic signed [W-1:0] res_z;
		logic                saturated;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;
		logic       mul_en;
		logic [2:0] mul_idx;
		logic       sq_init;
		logic       sq_step;
		logic       dv_init;
		logic       dv_step;
		logic       commit;
		kind_t      kind;
	} cmd_t;

	typedef struct packed {
		logic         sat;
		logic [W-1:0] val;
	} clamp_t;

	// clamp a wide signed value to the signed W-bit range
	function automatic clamp_t clamp_w(input logic signed [DIFF_W-1:0] v);
		clamp_t r;
		logic signed [DIFF_W-1:0] hi;
		logic signed [DIFF_W-1:0] lo;
		hi = DIFF_W'((65'sd1 <<< (W - 1)) - 65'sd1);
		lo = -DIFF_W'(65'sd1 <<< (W - 1));
		r.sat = 1'b0;
		r.val = v[W-1:0];
		if (v > hi) begin
			r.sat = 1'b1;
			r.val = {1'b0, {(W-1){1'b1}}};
		end else if (v < lo) begin
			r.sat = 1'b1;
			r.val = {1'b1, {(W-1){1'b0}}};
		end
		return r;
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] c);
		return c[W-1] ? W'(-c) : W'(c);
	endfunction

endpackage

// ----- design/vacn_if.sv -----
// ----------------------------------------------------------------------------
// vacn_in_if / vacn_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface vacn_in_if;
	import vacn_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vacn_out_if;
	import vacn_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- design/vacn_ctrl.sv -----
// ----------------------------------------------------------------------------
// vacn_ctrl
// Sequencer: multiply passes, square root steps, divide steps, commit.
// ----------------------------------------------------------------------------
module vacn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_kind,
	output logic           out_valid,
	input  logic           out_ready,
	output vacn_pkg::cmd_t cmd
);
	import vacn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_SQ_INIT, ST_SQ, ST_DV_INIT, ST_DV, ST_COMMIT
	} state_t;

	state_t           state_q;
	kind_t            kind_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.kind    = kind_q;
		cmd.capture = accept;
		cmd.mul_idx = cnt_q[2:0];
		unique case (state_q)
			ST_IDLE:    ;
			ST_MUL:     cmd.mul_en  = 1'b1;
			ST_SQ_INIT: cmd.sq_init = 1'b1;
			ST_SQ:      cmd.sq_step = 1'b1;
			ST_DV_INIT: cmd.dv_init = 1'b1;
			ST_DV:      cmd.dv_step = 1'b1;
			ST_COMMIT:  cmd.commit  = slot_free;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= KIND_LOAD;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// new result wins over the clear of the one leaving
			if (state_q == ST_COMMIT && slot_free)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						kind_q <= kind_t'(in_kind);
						if (kind_t'(in_kind) == KIND_CROSS || kind_t'(in_kind) == KIND_NORM)
							state_q <= ST_MUL;
						else
							state_q <= ST_COMMIT;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (kind_q == KIND_CROSS && cnt_q == CNT_W'(MUL_CROSS - 1)) begin
						state_q <= ST_COMMIT;
					end else if (kind_q == KIND_NORM && cnt_q == CNT_W'(MUL_NORM - 1)) begin
						state_q <= ST_SQ_INIT;
					end
				end
				ST_SQ_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQRT_STEPS - 1))
						state_q <= ST_DV_INIT;
				end
				ST_DV_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_DV;
				end
				ST_DV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready high right after a transfer in");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result overwritten while waiting");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit without result valid");
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_en, cmd.sq_init, cmd.sq_step, cmd.dv_init, cmd.dv_step,
			cmd.commit}))
		else $error("datapath commands overlap");
`endif

endmodule

// ----- design/vacn_dp.sv -----
// ----------------------------------------------------------------------------
// vacn_dp
// Vector state, shared multiplier, bit-serial square root, three dividers.
// ----------------------------------------------------------------------------
module vacn_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  vacn_pkg::cmd_t      cmd,
	input  vacn_pkg::in_item_t  in_data,
	output vacn_pkg::out_item_t out_data
);
	import vacn_pkg::*;

	logic signed [W-1:0]      vec_q [3];
	logic signed [W-1:0]      op_q  [3];
	logic signed [PROD_W-1:0] p_q   [MUL_CROSS];
	logic signed [W-1:0]      mul_a;
	logic signed [W-1:0]      mul_b;
	logic signed [PROD_W-1:0] prod;

	logic [PROD_W-1:0] n_q;
	logic [REM_W-1:0]  rem_q;
	logic [W-1:0]      root_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;

	logic [W:0]           r_q [3];
	logic [DIV_STEPS-1:0] qt_q [3];

	logic signed [W-1:0] nv   [3];
	logic                nsat;
	out_item_t           res_q;

	assign out_data = res_q;

	// multiplier operand select
	always_comb begin
		mul_a = vec_q[0];
		mul_b = op_q[0];
		if (cmd.kind == KIND_NORM) begin
			unique case (cmd.mul_idx)
				3'd0:    begin mul_a = vec_q[0]; mul_b = vec_q[0]; end
				3'd1:    begin mul_a = vec_q[1]; mul_b = vec_q[1]; end
				default: begin mul_a = vec_q[2]; mul_b = vec_q[2]; end
			endcase
		end else begin
			unique case (cmd.mul_idx)
				3'd0:    begin mul_a = vec_q[1]; mul_b = op_q[2]; end
				3'd1:    begin mul_a = vec_q[2]; mul_b = op_q[1]; end
				3'd2:    begin mul_a = vec_q[2]; mul_b = op_q[0]; end
				3'd3:    begin mul_a = vec_q[0]; mul_b = op_q[2]; end
				3'd4:    begin mul_a = vec_q[0]; mul_b = op_q[1]; end
				default: begin mul_a = vec_q[1]; mul_b = op_q[0]; end
			endcase
		end
	end

	assign prod   = mul_a * mul_b;
	assign rem_sh = {rem_q[REM_W-3:0], n_q[PROD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});

	// new vector for the committed operation
	always_comb begin
		clamp_t              c;
		logic signed [DIFF_W-1:0] d;
		logic [W-1:0]        qv;
		c    = '0;
		d    = '0;
		qv   = '0;
		nsat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			nv[i] = vec_q[i];
			unique case (cmd.kind)
				KIND_LOAD: nv[i] = op_q[i];
				KIND_ADD: begin
					d = DIFF_W'(vec_q[i]) + DIFF_W'(op_q[i]);
					c = clamp_w(d);
					nv[i] = c.val;
					nsat = nsat | c.sat;
				end
				KIND_CROSS: begin
					d = (DIFF_W'(p_q[2*i]) - DIFF_W'(p_q[2*i+1])) >>> FRAC_BITS;
					c = clamp_w(d);
					nv[i] = c.val;
					nsat = nsat | c.sat;
				end
				KIND_NORM: begin
					qv = W'(qt_q[i]);
					if (root_q != '0)
						nv[i] = vec_q[i][W-1] ? -qv : qv;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				vec_q[i] <= '0;
		end else if (cmd.commit) begin
			for (int i = 0; i < 3; i++)
				vec_q[i] <= nv[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q[0] <= in_data.op_x;
			op_q[1] <= in_data.op_y;
			op_q[2] <= in_data.op_z;
		end
		if (cmd.mul_en)
			p_q[cmd.mul_idx] <= prod;
		if (cmd.sq_init) begin
			n_q    <= PROD_W'(p_q[0]) + PROD_W'(p_q[1]) + PROD_W'(p_q[2]);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sq_step) begin
			n_q <= {n_q[PROD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[W-2:0], 1'b0};
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.dv_init) begin
				r_q[i]  <= {1'b0, mag(vec_q[i])};
				qt_q[i] <= '0;
			end
			if (cmd.dv_step) begin
				if (r_q[i] >= {1'b0, root_q}) begin
					r_q[i]  <= {(W'(r_q[i] - {1'b0, root_q})), 1'b0};
					qt_q[i] <= {qt_q[i][DIV_STEPS-2:0], 1'b1};
				end else begin
					r_q[i]  <= {r_q[i][W-1:0], 1'b0};
					qt_q[i] <= {qt_q[i][DIV_STEPS-2:0], 1'b0};
				end
			end
		end
		if (cmd.commit) begin
			res_q.res_x     <= nv[0];
			res_q.res_y     <= nv[1];
			res_q.res_z     <= nv[2];
			res_q.saturated <= nsat;
		end
	end

endmodule

// ----- design/vector3_accumulate_cross_normalize.sv -----
// ----------------------------------------------------------------------------
// vector3_accumulate_cross_normalize
// Keeps one signed Q16.16 3D vector and applies load/add/cross/normalize.
// ----------------------------------------------------------------------------
// Use:
//   in_ch carries one item: kind (load, add, cross, normalize) and an
//   operand vector. A transfer happens when valid and ready are both high.
//   out_ch returns exactly one result per item: the stored vector after
//   the operation and a flag set when add or cross clamped a component.
// Work per item, from item accepted to result valid:
//   load, add   straight to the commit of the result
//   cross       six products through one 32x32 multiplier
//   normalize   3 squares, 32 one-bit square root steps,
//               17 restoring divide steps run on three dividers at once
//   in_ready rises together with the result valid, so the block takes no
//   new item until the result of the last one is committed.
// Reset clears the vector to zero and empties the result register.
// When the receiver stalls, the result holds in its register; the block
// still takes the next item and works on it, waiting only at the point
// where the new result would be written.
// ----------------------------------------------------------------------------
module vector3_accumulate_cross_normalize (
	input  logic  clk,
	input  logic  arst_n,
	vacn_in_if.sink    in_ch,
	vacn_out_if.source out_ch
);
	import vacn_pkg::*;

	cmd_t cmd;

	// sequencer: owns the handshakes and the step counts
	vacn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_kind   (in_ch.data.kind),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// arithmetic and the stored vector
	vacn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_ch.data),
		.out_data (out_ch.data)
	);

endmodule
